// ----- src/ste_pkg.sv -----
`default_nettype none
package ste_pkg;

  localparam int unsigned DefSites      = 8;
  localparam int unsigned DefTableDepth = 256;
  localparam int unsigned CfgBits       = 8;
  localparam int unsigned SiteW         = 3;
  localparam int unsigned NumTerms      = 6;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 64;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_EXPAND = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADROW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    TT_X  = 3'd0,
    TT_Y  = 3'd1,
    TT_Z  = 3'd2,
    TT_XX = 3'd3,
    TT_YY = 3'd4,
    TT_ZZ = 3'd5
  } term_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COEF_X   = 3'd0,
    REG_COEF_Y   = 3'd1,
    REG_COEF_Z   = 3'd2,
    REG_COEF_XX  = 3'd3,
    REG_COEF_YY  = 3'd4,
    REG_COEF_ZZ  = 3'd5,
    REG_OUTSIDE  = 3'd6,
    REG_SITES    = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW,
    S_TERM,
    S_SRCH,
    S_CMP,
    S_EMIT,
    S_FIN
  } state_e;

  typedef struct packed {
    logic               skip;
    logic [CfgBits-1:0] col_cfg;
    logic [31:0]        re;
    logic [31:0]        im;
  } term_t;

  typedef struct packed {
    logic [7:0]         row;
    logic [7:0]         col;
    logic [31:0]        re;
    logic [31:0]        im;
    logic               is_new;
    logic [CfgBits-1:0] new_config;
    status_e            status;
    logic               last;
  } res_t;

  function automatic logic [31:0] neg_sat(input logic [31:0] v);
    if (v == 32'h8000_0000) begin
      return 32'h7FFF_FFFF;
    end
    return 32'd0 - v;
  endfunction

endpackage
`default_nettype wire

// ----- src/ste_req_if.sv -----
`default_nettype none
interface ste_req_if import ste_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [CfgBits-1:0] config_bits;
  logic [7:0]         row_index;

  modport source (output valid, req_type, config_bits, row_index, input ready);
  modport sink (input valid, req_type, config_bits, row_index, output ready);
endinterface
`default_nettype wire

// ----- src/ste_rsp_if.sv -----
`default_nettype none
interface ste_rsp_if import ste_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [7:0]         row_out;
  logic [7:0]         col_out;
  logic signed [31:0] coef_re;
  logic signed [31:0] coef_im;
  logic               is_new;
  logic [CfgBits-1:0] new_config;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, row_out, col_out, coef_re, coef_im, is_new, new_config,
                  status, last, input ready);
  modport sink (input valid, row_out, col_out, coef_re, coef_im, is_new, new_config,
                status, last, output ready);
endinterface
`default_nettype wire

// ----- src/spin_chain_term_expander.sv -----
// clear and load requests leave the block idle; it is ready again the next cycle
// expand: the row is fetched (S_ROW), then each term is skipped or looked up: the table
// is searched from the newest entry down (S_SRCH, S_CMP, one shared compare); a miss adds an
// entry if outside is set, else drops the term; a bad row goes to S_FIN; stalls add their wait
// one result is held back until the next is known, so the final one can carry last
// rst_ni (async, active low) empties the table and restores register defaults, not its contents
`default_nettype none
module spin_chain_term_expander import ste_pkg::*; #(
  parameter int unsigned SITES       = DefSites,
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  ste_req_if.sink                  req_i,
  ste_rsp_if.source                rsp_o
);

  localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW   = (CW > 8) ? CW : 8;
  localparam int unsigned MaxN = (SITES < CfgBits) ? SITES : CfgBits;

  logic [63:0]        coef_q [NumTerms];
  logic               outside_q;
  logic [3:0]         sites_q;

  logic [CfgBits-1:0] mem [TABLE_DEPTH];
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [CfgBits-1:0] wdata, rdata_q;

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d, e_q, e_d;
  logic [2:0]         t_q, t_d;
  logic [SiteW-1:0]   s_q, s_d;
  logic [CfgBits-1:0] cfg_q, cfg_d;
  logic [7:0]         row_q, row_d;
  term_t              term, term_q, term_d;
  res_t               nres_q, nres_d, pend_q, pend_d, out_q, out_d;
  logic               pend_v_q, pend_v_d, out_v_q, out_v_d;

  logic [3:0]         n;
  logic [CfgBits-1:0] mask;
  logic               out_free, adv, accept, hit;
  logic [63:0]        coef_sel;

  always_comb begin
    n = (sites_q == 4'd0) ? 4'd1 : sites_q;
    if (n > 4'(MaxN)) begin
      n = 4'(MaxN);
    end
    mask = CfgBits'((9'd1 << n) - 9'd1);
  end

  assign coef_sel = (t_q < 3'(NumTerms)) ? coef_q[t_q] : 64'd0;

  ste_term_calc u_term (
    .term_i (t_q),
    .site_i (s_q),
    .cfg_i  (cfg_q),
    .coef_i (coef_sel),
    .term_o (term)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumTerms; i++) begin
        coef_q[i] <= '0;
      end
      outside_q <= 1'b0;
      sites_q   <= 4'd8;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_COEF_X, REG_COEF_Y, REG_COEF_Z, REG_COEF_XX, REG_COEF_YY, REG_COEF_ZZ: begin
          coef_q[cfg_idx_i] <= cfg_data_i;
        end
        REG_OUTSIDE: outside_q <= cfg_data_i[0];
        REG_SITES:   sites_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_v_q || rsp_o.ready;
  assign hit      = ((rdata_q ^ term_q.col_cfg) & mask) == '0;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    e_d      = e_q;
    t_d      = t_q;
    s_d      = s_q;
    cfg_d    = cfg_q;
    row_d    = row_q;
    term_d   = term_q;
    nres_d   = nres_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q && !rsp_o.ready;
    we       = 1'b0;
    waddr    = count_q[AW-1:0];
    wdata    = req_i.config_bits;
    raddr    = AW'(req_i.row_index);
    adv      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.req_type)
            REQ_CLEAR: count_d = '0;
            REQ_LOAD: begin
              if (count_q < CW'(TABLE_DEPTH)) begin
                we      = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            REQ_EXPAND: begin
              row_d = req_i.row_index;
              if (XW'(req_i.row_index) >= XW'(count_q)) begin
                pend_d            = '0;
                pend_d.row        = req_i.row_index;
                pend_d.status     = ST_BADROW;
                pend_v_d          = 1'b1;
                state_d           = S_FIN;
              end else begin
                state_d = S_ROW;
              end
            end
            default: ;
          endcase
        end
      end
      S_ROW: begin
        cfg_d   = rdata_q;
        t_d     = '0;
        s_d     = '0;
        state_d = S_TERM;
      end
      S_TERM: begin
        if (t_q >= 3'(NumTerms)) begin
          state_d = S_FIN;
        end else if (term.skip) begin
          adv = 1'b1;
        end else begin
          term_d  = term;
          e_d     = count_q;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        raddr = AW'(e_q - CW'(1));
        nres_d            = '0;
        nres_d.row        = row_q;
        nres_d.re         = term_q.re;
        nres_d.im         = term_q.im;
        nres_d.new_config = term_q.col_cfg;
        if (e_q == '0) begin
          if (!outside_q) begin
            adv     = 1'b1;
            state_d = S_TERM;
          end else if (count_q < CW'(TABLE_DEPTH)) begin
            we            = 1'b1;
            wdata         = term_q.col_cfg;
            nres_d.col    = 8'(count_q);
            nres_d.is_new = 1'b1;
            count_d       = count_q + CW'(1);
            state_d       = S_EMIT;
          end else begin
            nres_d.status = ST_FULL;
            state_d       = S_EMIT;
          end
        end else begin
          e_d     = e_q - CW'(1);
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (hit) begin
          nres_d.col = 8'(e_q);
          state_d    = S_EMIT;
        end else begin
          state_d = S_SRCH;
        end
      end
      S_EMIT: begin
        if (!pend_v_q) begin
          pend_d   = nres_q;
          pend_v_d = 1'b1;
          adv      = 1'b1;
          state_d  = S_TERM;
        end else if (out_free) begin
          out_d      = pend_q;
          out_d.last = 1'b0;
          out_v_d    = 1'b1;
          pend_d     = nres_q;
          adv        = 1'b1;
          state_d    = S_TERM;
        end
      end
      S_FIN: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_v_d    = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (adv) begin
      if (4'(s_q) + 4'd1 >= n) begin
        s_d = '0;
        t_d = t_q + 3'd1;
      end else begin
        s_d = s_q + SiteW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q    <= e_d;
    t_q    <= t_d;
    s_q    <= s_d;
    cfg_q  <= cfg_d;
    row_q  <= row_d;
    term_q <= term_d;
    nres_q <= nres_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = out_v_q;
  assign rsp_o.row_out    = out_q.row;
  assign rsp_o.col_out    = out_q.col;
  assign rsp_o.coef_re    = out_q.re;
  assign rsp_o.coef_im    = out_q.im;
  assign rsp_o.is_new     = out_q.is_new;
  assign rsp_o.new_config = out_q.new_config;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.last       = out_q.last;

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_v_q) else $error("held result left behind");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH)) else $error("entry count overflow");

  a_cmp_after_srch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> $past(state_q) == S_SRCH) else $error("compare without read");

  a_badrow_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.status == ST_BADROW |-> out_q.last) else $error("bad row not last");

endmodule
`default_nettype wire

// ----- src/ste_term_calc.sv -----
`default_nettype none
module ste_term_calc import ste_pkg::*; (
  input  wire logic [2:0]         term_i,
  input  wire logic [SiteW-1:0]   site_i,
  input  wire logic [CfgBits-1:0] cfg_i,
  input  wire logic [63:0]        coef_i,
  output term_t                   term_o
);

  logic [31:0]        re, im;
  logic               b, bp;
  logic [CfgBits-1:0] m1, m2;

  always_comb begin
    re = coef_i[63:32];
    im = coef_i[31:0];
    b  = cfg_i[site_i];
    m1 = CfgBits'(1) << site_i;
    m2 = (site_i == '0) ? '0 : (CfgBits'(1) << (site_i - SiteW'(1)));
    bp = (site_i == '0) ? 1'b0 : cfg_i[site_i - SiteW'(1)];
    term_o.skip    = (coef_i == 64'd0);
    term_o.col_cfg = cfg_i;
    term_o.re      = re;
    term_o.im      = im;
    unique case (term_i)
      TT_X: begin
        term_o.col_cfg = cfg_i ^ m1;
      end
      TT_Y: begin
        term_o.col_cfg = cfg_i ^ m1;
        if (!b) begin
          term_o.re = neg_sat(im);
          term_o.im = re;
        end else begin
          term_o.re = im;
          term_o.im = neg_sat(re);
        end
      end
      TT_Z: begin
        if (b) begin
          term_o.re = neg_sat(re);
          term_o.im = neg_sat(im);
        end
      end
      TT_XX: begin
        term_o.skip    = term_o.skip || (site_i == '0);
        term_o.col_cfg = cfg_i ^ m1 ^ m2;
      end
      TT_YY: begin
        term_o.skip    = term_o.skip || (site_i == '0);
        term_o.col_cfg = cfg_i ^ m1 ^ m2;
        if (b == bp) begin
          term_o.re = neg_sat(re);
          term_o.im = neg_sat(im);
        end
      end
      TT_ZZ: begin
        term_o.skip = term_o.skip || (site_i == '0);
        if (b != bp) begin
          term_o.re = neg_sat(re);
          term_o.im = neg_sat(im);
        end
      end
      default: begin
        term_o.skip = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire
